// File: hw/rtl/lru_frame_replacer_unit_defines.svh
// Assertion macros for the LRU frame replacer.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef LRU_FRAME_REPLACER_UNIT_DEFINES_SVH
`define LRU_FRAME_REPLACER_UNIT_DEFINES_SVH

// same-cycle implication
`define LFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfr: same-cycle check failed");

// next-cycle implication
`define LFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfr: next-cycle check failed");

`endif

// File: hw/rtl/lfr_pkg.sv
// Package for the LRU frame replacer: sizes, request codes, item types.
// No dependencies.
`default_nettype none

package lfr_pkg;

	localparam int NUM_FRAMES = 64;
	localparam int FID_W      = 6;
	localparam int CNT_W      = 7;
	localparam int REQ_W      = 2;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

	localparam logic [REQ_W-1:0] REQ_VICTIM = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PIN    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_UNPIN  = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [FID_W-1:0] frame_no;
	} lfr_req_t;

	typedef struct packed {
		logic             found;
		logic [FID_W-1:0] victim_frame;
		logic [CNT_W-1:0] occupancy;
	} lfr_rsp_t;

	// broadcast to every queue cell
	typedef struct packed {
		logic             pop;
		logic             pin;
		logic             push;
		logic [FID_W-1:0] fid;
	} lfr_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/lfr_cell.sv
// One queue slot of the LRU frame replacer: valid bit and frame id.
// Depends on lfr_pkg.
`default_nettype none

module lfr_cell import lfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lfr_ctl_t         ctl,
	input  logic             seen_in,
	output logic             seen_out,
	input  logic             prev_valid,
	input  logic             nxt_valid,
	input  logic [FID_W-1:0] nxt_id,
	output logic             valid,
	output logic [FID_W-1:0] id,
	output logic             match
);

	logic             valid_q;
	logic [FID_W-1:0] id_q;
	logic             shift;
	logic             load;

	assign match    = valid_q && (id_q == ctl.fid);
	assign seen_out = seen_in | (ctl.pin & match);
	assign shift    = (ctl.pop | ctl.pin) & seen_out;
	// tail slot: first empty slot after a full one
	assign load     = ctl.push & !valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			id_q <= nxt_id;
		end else if (load) begin
			id_q <= ctl.fid;
		end
	end

	assign valid = valid_q;
	assign id    = id_q;

endmodule

`default_nettype wire

// File: hw/rtl/lru_frame_replacer_unit.sv
// LRU frame replacer: 64 queue cells, oldest frame at cell 0.
// Channels: req (valid/stall, lfr_req_t) in, rsp (valid/stall, lfr_rsp_t) out,
// plus an APB port with one register, capacity, at byte address 0.
// Each request item gives exactly one response item in the cycle after it is
// accepted; one item per cycle is sustained unless the response is held.
// The whole request (pop at the head, remove anywhere, append at the tail)
// is done in the cell row in the cycle of acceptance; the length of that
// cycle is set by the match ripple across the row.
// The response sits in a single output register; while it is held under
// rsp_stall, req_stall is raised and no further item is taken.
// Reset empties the queue (cell valid bits cleared, occupancy zero) and sets
// capacity to 64. The user writes capacity only while the block is idle; not enforced.
// Depends on lfr_pkg, lfr_cell and lru_frame_replacer_unit_defines.svh.
`default_nettype none
`include "lru_frame_replacer_unit_defines.svh"

module lru_frame_replacer_unit import lfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  lfr_req_t          req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lfr_rsp_t          rsp
);

	logic [CNT_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             rsp_valid_q;
	lfr_rsp_t         rsp_q;

	lfr_ctl_t         ctl;
	logic             req_acc;
	logic             fid_ok;
	logic             room;
	logic             hit;
	logic             popped;
	logic [NUM_FRAMES:0]   seen;
	logic [NUM_FRAMES-1:0] valid_vec;
	logic [NUM_FRAMES-1:0] match_vec;
	logic [FID_W-1:0]      id_arr [NUM_FRAMES];

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CNT_W-1:0];
		end
	end

	// request decode
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_acc   = req_valid && !req_stall;
	assign fid_ok    = CNT_W'(req.frame_no) < CNT_W'(NUM_FRAMES);
	assign room      = (count_q < capacity_q) && (count_q < CNT_W'(NUM_FRAMES));
	assign hit       = |match_vec;

	always_comb begin
		ctl.fid  = req.frame_no;
		ctl.pop  = req_acc && (req.req_type == REQ_VICTIM);
		ctl.pin  = req_acc && (req.req_type == REQ_PIN) && fid_ok;
		ctl.push = req_acc && (req.req_type == REQ_UNPIN) && fid_ok && !hit && room;
	end

	// pop shifts every cell; pin shifts from the matching cell onwards
	assign seen[0] = ctl.pop;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_FRAMES; gi++) begin : g_cell
			logic             prev_v;
			logic             nxt_v;
			logic [FID_W-1:0] nxt_i;

			if (gi == 0) begin : g_head
				assign prev_v = 1'b1;
			end else begin : g_body
				assign prev_v = valid_vec[gi-1];
			end

			if (gi == NUM_FRAMES-1) begin : g_tail
				assign nxt_v = 1'b0;
				assign nxt_i = '0;
			end else begin : g_link
				assign nxt_v = valid_vec[gi+1];
				assign nxt_i = id_arr[gi+1];
			end

			lfr_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.seen_in    (seen[gi]),
				.seen_out   (seen[gi+1]),
				.prev_valid (prev_v),
				.nxt_valid  (nxt_v),
				.nxt_id     (nxt_i),
				.valid      (valid_vec[gi]),
				.id         (id_arr[gi]),
				.match      (match_vec[gi])
			);
		end
	endgenerate

	// occupancy
	assign popped = ctl.pop && valid_vec[0];

	always_comb begin
		count_nxt = count_q;
		if (popped || (ctl.pin && seen[NUM_FRAMES])) begin
			count_nxt = count_q - CNT_W'(1);
		end else if (ctl.push) begin
			count_nxt = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (req_acc) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			rsp_q.found        <= popped;
			rsp_q.victim_frame <= popped ? id_arr[0] : '0;
			rsp_q.occupancy    <= count_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`LFR_ASSERT_NOW(a_prefix, 1'b1, $countones(valid_vec) == int'(count_q))
	`LFR_ASSERT_NOW(a_cnt_max, 1'b1, count_q <= CNT_W'(NUM_FRAMES))
	`LFR_ASSERT_NEXT(a_rsp_after_req, req_acc, rsp_valid_q && (rsp_q.occupancy == count_q))
	`LFR_ASSERT_NOW(a_push_no_dup, ctl.push, !hit && (count_q < capacity_q))

endmodule

`default_nettype wire
